>>> hw/rtl/bcd_up_down_counter_display_top_assert.svh
// Assertion macros for the BCD up/down counter display block.
`ifndef BCD_UP_DOWN_COUNTER_DISPLAY_TOP_ASSERT_SVH
`define BCD_UP_DOWN_COUNTER_DISPLAY_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BCDUDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BCDUDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCDUDC_ASSERT_SAME(label, ante, cons, msg)

`define BCDUDC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bcdudc_pkg.sv
// Types, constants and helper functions of the BCD up/down counter display block.
package bcdudc_pkg;

    typedef logic [6:0] count_t;
    typedef logic [7:0] tick_t;
    typedef logic [3:0] digit_t;
    typedef logic [6:0] seg_t;
    typedef logic [2:0] cfg_index_t;
    typedef logic [7:0] cfg_data_t;

    localparam cfg_index_t REG_TOP_COUNT      = 3'd0;
    localparam cfg_index_t REG_UP_PERIOD      = 3'd1;
    localparam cfg_index_t REG_DOWN_PERIOD    = 3'd2;
    localparam cfg_index_t REG_UP_LED_LIMIT   = 3'd3;
    localparam cfg_index_t REG_DOWN_LED_LIMIT = 3'd4;

    localparam count_t RST_TOP_COUNT      = 7'd59;
    localparam tick_t  RST_UP_PERIOD      = 8'd20;
    localparam tick_t  RST_DOWN_PERIOD    = 8'd50;
    localparam tick_t  RST_UP_LED_LIMIT   = 8'd25;
    localparam tick_t  RST_DOWN_LED_LIMIT = 8'd10;

    localparam seg_t SEG_CODES [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

    typedef struct packed {
        logic tens_digit_on;
        seg_t segments;
        logic led_on;
    } out_item_t;

    // tens = floor(count / 10) via reciprocal 205 / 2048, exact for 7-bit counts
    function automatic digit_t bcd_tens(input count_t value);
        logic [14:0] prod;
        prod = {8'd0, value} * 15'd205;
        return prod[14:11];
    endfunction

    function automatic digit_t bcd_units(input count_t value);
        logic [6:0] tens_x10;
        logic [6:0] diff;
        tens_x10 = {3'd0, bcd_tens(value)} * 7'd10;
        diff     = value - tens_x10;
        return diff[3:0];
    endfunction

endpackage

>>> hw/rtl/bcdudc_if.sv
// Valid/ready channel interfaces for the input ticks and the display items.
interface bcdudc_in_if;
    logic valid;
    logic ready;
    logic count_up;

    modport source (output valid, output count_up, input ready);
    modport sink (input valid, input count_up, output ready);
endinterface

interface bcdudc_out_if;
    logic valid;
    logic ready;
    logic tens_digit_on;
    logic [6:0] segments;
    logic led_on;

    modport source (output valid, output tens_digit_on, output segments, output led_on,
                    input ready);
    modport sink (input valid, input tens_digit_on, input segments, input led_on,
                  output ready);
endinterface

>>> hw/rtl/bcd_up_down_counter_display_top.sv
// Top level of the BCD up/down counter with multiplexed seven-segment display.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    count_up
//  out_ch    out  valid/ready    tens_digit_on, segments[6:0], led_on
//  cfg       in   cfg_we only    cfg_index[2:0], cfg_data[7:0]
//
//  One item per cycle unless out_ch stalls; a result follows in the next cycle.
//  The count, tick and LED state update at the accepting edge; the result register
//  holds the display item until taken.
//  in_ch.ready stays high while the result register is empty or being drained.
//  Reset: count 0, LED off, tens digit shown first, registers at their defaults.
`include "bcd_up_down_counter_display_top_assert.svh"

module bcd_up_down_counter_display_top (
    input  logic                    clk,
    input  logic                    rst_n,
    bcdudc_in_if.sink               in_ch,
    bcdudc_out_if.source            out_ch,
    input  logic                    cfg_we,
    input  bcdudc_pkg::cfg_index_t  cfg_index,
    input  bcdudc_pkg::cfg_data_t   cfg_data
);
    import bcdudc_pkg::*;

    count_t    top_count_reg;
    tick_t     up_period_reg;
    tick_t     down_period_reg;
    tick_t     up_led_limit_reg;
    tick_t     down_led_limit_reg;

    count_t    count_value_reg, count_value_next;
    tick_t     tick_count_reg, tick_count_next;
    tick_t     period_length_reg, period_length_next;
    logic      started_reg, started_next;
    tick_t     led_step_count_reg, led_step_count_next;
    logic      led_level_reg, led_level_next;
    logic      show_tens_reg, show_tens_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    logic      in_fire;
    tick_t     period_eff;
    tick_t     ticks_inc;
    tick_t     led_inc;
    logic      step;
    digit_t    digit;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.tens_digit_on = out_item_reg.tens_digit_on;
    assign out_ch.segments      = out_item_reg.segments;
    assign out_ch.led_on        = out_item_reg.led_on;

    always_comb
    begin
        period_eff = started_reg ? period_length_reg
                                 : (in_ch.count_up ? up_period_reg : down_period_reg);
        ticks_inc  = tick_count_reg + 8'd1;
        led_inc    = led_step_count_reg + 8'd1;
        step       = (ticks_inc >= period_eff) || (ticks_inc == 8'd0);
        digit      = show_tens_reg ? bcd_tens(count_value_reg) : bcd_units(count_value_reg);

        count_value_next    = count_value_reg;
        tick_count_next     = tick_count_reg;
        period_length_next  = period_length_reg;
        started_next        = started_reg;
        led_step_count_next = led_step_count_reg;
        led_level_next      = led_level_reg;
        show_tens_next      = show_tens_reg;

        if (in_fire)
        begin
            show_tens_next     = !show_tens_reg;
            started_next       = 1'b1;
            period_length_next = period_eff;
            if (step)
            begin
                tick_count_next = 8'd0;
                if (in_ch.count_up)
                begin
                    period_length_next = up_period_reg;
                    if (count_value_reg >= top_count_reg)
                    begin
                        count_value_next    = 7'd0;
                        led_level_next      = 1'b1;
                        led_step_count_next = 8'd0;
                    end
                    else
                    begin
                        count_value_next = count_value_reg + 7'd1;
                        if (led_inc == up_led_limit_reg)
                        begin
                            led_level_next      = 1'b0;
                            led_step_count_next = 8'd0;
                        end
                        else
                        begin
                            led_step_count_next = led_inc;
                        end
                    end
                end
                else
                begin
                    period_length_next = down_period_reg;
                    if (count_value_reg == 7'd0)
                    begin
                        count_value_next    = top_count_reg;
                        led_level_next      = 1'b1;
                        led_step_count_next = 8'd0;
                    end
                    else
                    begin
                        count_value_next = count_value_reg - 7'd1;
                        if (led_inc == down_led_limit_reg)
                        begin
                            led_level_next      = 1'b0;
                            led_step_count_next = 8'd0;
                        end
                        else
                        begin
                            led_step_count_next = led_inc;
                        end
                    end
                end
            end
            else
            begin
                tick_count_next = ticks_inc;
            end
        end

        out_valid_next              = in_fire || (out_valid_reg && !out_ch.ready);
        out_item_next               = out_item_reg;
        if (in_fire)
        begin
            out_item_next.tens_digit_on = show_tens_reg;
            out_item_next.segments      = SEG_CODES[digit];
            out_item_next.led_on        = led_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg      <= RST_TOP_COUNT;
            up_period_reg      <= RST_UP_PERIOD;
            down_period_reg    <= RST_DOWN_PERIOD;
            up_led_limit_reg   <= RST_UP_LED_LIMIT;
            down_led_limit_reg <= RST_DOWN_LED_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP_COUNT:      top_count_reg      <= cfg_data[6:0];
                REG_UP_PERIOD:      up_period_reg      <= cfg_data;
                REG_DOWN_PERIOD:    down_period_reg    <= cfg_data;
                REG_UP_LED_LIMIT:   up_led_limit_reg   <= cfg_data;
                REG_DOWN_LED_LIMIT: down_led_limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_value_reg    <= '0;
            tick_count_reg     <= '0;
            period_length_reg  <= '0;
            started_reg        <= 1'b0;
            led_step_count_reg <= '0;
            led_level_reg      <= 1'b0;
            show_tens_reg      <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            count_value_reg    <= count_value_next;
            tick_count_reg     <= tick_count_next;
            period_length_reg  <= period_length_next;
            started_reg        <= started_next;
            led_step_count_reg <= led_step_count_next;
            led_level_reg      <= led_level_next;
            show_tens_reg      <= show_tens_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    `BCDUDC_ASSERT_NEXT(a_fire_fills_output, in_fire, out_valid_reg,
        "accepted item did not reach the result register")
    `BCDUDC_ASSERT_SAME(a_stall_blocks_input, out_valid_reg && !out_ch.ready, !in_ch.ready,
        "input accepted while result register is stalled")
    `BCDUDC_ASSERT_NEXT(a_digit_alternates, in_fire, show_tens_reg != $past(show_tens_reg),
        "digit select did not alternate on an accepted item")
    `BCDUDC_ASSERT_NEXT(a_fire_starts, in_fire, started_reg,
        "period not loaded after first item")
    `BCDUDC_ASSERT_SAME(a_led_on_wrap, $rose(led_level_reg),
        count_value_reg == 7'd0 || count_value_reg == $past(top_count_reg),
        "LED lit without a count wrap")

endmodule
